>>> hdl/frc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the real/complex FIR filter.
// Used by the interfaces, the tap cell, the top level and the checker.
package frc_pkg;

  localparam int TAP_INDEX_BITS   = 6;
  localparam int ACTIVE_TAPS_BITS = 7;
  localparam int OP_BITS          = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_REAL    = 2'd0,
    OP_COMPLEX = 2'd1,
    OP_WRITE   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } state_t;

  // Control broadcast from the sequencer to every tap cell.
  typedef struct packed {
    logic shift_real;
    logic shift_cplx;
    logic clear;
    logic coef_we;
    logic adv;
    logic cplx;
  } cell_ctl_t;

endpackage

>>> hdl/frc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the FIR filter: sample/command words in,
// filtered words out. Depends on frc_pkg for the fixed field widths.
interface frc_in_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
);
  logic                                    valid;
  logic                                    ready;
  logic [frc_pkg::OP_BITS-1:0]             operation;
  logic signed [SAMPLE_BITS-1:0]           sample_re;
  logic signed [SAMPLE_BITS-1:0]           sample_im;
  logic [frc_pkg::TAP_INDEX_BITS-1:0]      tap_index;
  logic signed [COEF_BITS-1:0]             tap_value;

  modport source (output valid, operation, sample_re, sample_im, tap_index, tap_value,
                  input ready);
  modport sink   (input valid, operation, sample_re, sample_im, tap_index, tap_value,
                  output ready);
endinterface

interface frc_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] result_re;
  logic signed [SAMPLE_BITS-1:0] result_im;
  logic                          saturated;

  modport source (output valid, result_re, result_im, saturated, input ready);
  modport sink   (input valid, result_re, result_im, saturated, output ready);
endinterface

>>> hdl/fir_filter_real_complex.sv
`timescale 1ns / 1ps
// FIR filter over a chain of MAX_TAPS tap cells with real and complex delay lines.
// An accepted sample's partial sum walks the chain one cell per cycle, and its
// result word is registered at the output once the port can take it; a new sample
// is taken only after that load. Coefficient writes and clears keep the input ready.
// Reset clears both delay lines and active_taps; coefficients stay undefined until
// written. Depends on frc_pkg, frc_if and frc_cell.
module fir_filter_real_complex #(
  parameter int MAX_TAPS    = 64,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [frc_pkg::ACTIVE_TAPS_BITS-1:0]    cfg_data,
  frc_in_if.sink                                  din,
  frc_out_if.source                               dout
);
  import frc_pkg::*;

  localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(MAX_TAPS);
  localparam int RND_W    = ACC_BITS + 1;
  localparam int FRAC     = COEF_BITS - 3;
  localparam int IDX_W    = (($clog2(MAX_TAPS) > ACTIVE_TAPS_BITS) ?
                             $clog2(MAX_TAPS) : ACTIVE_TAPS_BITS) + 1;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (FRAC - 1);
  localparam logic signed [RND_W-1:0] MAXV = (RND_W'(1) << (SAMPLE_BITS - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] MINV = ~MAXV;

  state_t    state, state_next;
  cell_ctl_t ctl;
  logic      in_ready;
  logic      acc_in;
  logic      start;
  logic      load_out;
  logic      adv;

  logic [ACTIVE_TAPS_BITS-1:0] active_taps;
  logic                        cur_cplx;
  logic signed [SAMPLE_BITS-1:0] x_re, x_im;

  logic signed [SAMPLE_BITS-1:0] real_chain [0:MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] cre_chain  [0:MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] cim_chain  [0:MAX_TAPS];
  logic signed [ACC_BITS-1:0]    sum_re_chain [0:MAX_TAPS];
  logic signed [ACC_BITS-1:0]    sum_im_chain [0:MAX_TAPS];
  logic                          tok_chain [0:MAX_TAPS];

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_re, out_im;
  logic                          out_sat;
  logic [SAMPLE_BITS:0]          fin_re, fin_im;
  logic signed [SAMPLE_BITS-1:0] res_re, res_im;
  logic                          res_sat;

  // Round half up by FRAC bits, then clip; the top bit of the result is the clip flag.
  function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [ACC_BITS-1:0] s);
    logic signed [RND_W-1:0] r;
    r = (RND_W'(s) + HALF) >>> FRAC;
    if (r > MAXV) begin
      return {1'b1, MAXV[SAMPLE_BITS-1:0]};
    end else if (r < MINV) begin
      return {1'b1, MINV[SAMPLE_BITS-1:0]};
    end
    return {1'b0, r[SAMPLE_BITS-1:0]};
  endfunction

  assign acc_in   = din.valid && in_ready;
  assign load_out = tok_chain[MAX_TAPS] && (!out_valid || dout.ready);
  assign adv      = !tok_chain[MAX_TAPS] || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.adv        = adv;
    ctl.cplx       = cur_cplx;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (acc_in) begin
          unique case (op_t'(din.operation))
            OP_REAL: begin
              ctl.shift_real = 1'b1;
              state_next     = S_SWEEP;
            end
            OP_COMPLEX: begin
              ctl.shift_cplx = 1'b1;
              state_next     = S_SWEEP;
            end
            OP_WRITE: ctl.coef_we = 1'b1;
            OP_CLEAR: ctl.clear   = 1'b1;
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign din.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= '0;
    end else if (cfg_we) begin
      active_taps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= ctl.shift_real || ctl.shift_cplx;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_real || ctl.shift_cplx) begin
      cur_cplx <= ctl.shift_cplx;
      x_re     <= din.sample_re;
      x_im     <= din.sample_im;
    end
  end

  assign real_chain[0]   = din.sample_re;
  assign cre_chain[0]    = din.sample_re;
  assign cim_chain[0]    = din.sample_im;
  assign sum_re_chain[0] = '0;
  assign sum_im_chain[0] = '0;
  assign tok_chain[0]    = start;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
    frc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ACC_BITS    (ACC_BITS),
      .IDX_W       (IDX_W),
      .TAP         (j)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .coef_idx    (din.tap_index),
      .coef_data   (din.tap_value),
      .active_taps (active_taps),
      .real_in     (real_chain[j]),
      .cre_in      (cre_chain[j]),
      .cim_in      (cim_chain[j]),
      .real_out    (real_chain[j+1]),
      .cre_out     (cre_chain[j+1]),
      .cim_out     (cim_chain[j+1]),
      .tok_in      (tok_chain[j]),
      .sum_re_in   (sum_re_chain[j]),
      .sum_im_in   (sum_im_chain[j]),
      .tok_out     (tok_chain[j+1]),
      .sum_re_out  (sum_re_chain[j+1]),
      .sum_im_out  (sum_im_chain[j+1])
    );
  end

  always_comb begin
    fin_re = round_sat(sum_re_chain[MAX_TAPS]);
    fin_im = round_sat(sum_im_chain[MAX_TAPS]);
    if (active_taps == '0) begin
      // With no active taps the sample passes through untouched.
      res_re  = x_re;
      res_im  = cur_cplx ? x_im : '0;
      res_sat = 1'b0;
    end else begin
      res_re  = fin_re[SAMPLE_BITS-1:0];
      res_im  = cur_cplx ? fin_im[SAMPLE_BITS-1:0] : '0;
      res_sat = fin_re[SAMPLE_BITS] || (cur_cplx && fin_im[SAMPLE_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_re  <= res_re;
      out_im  <= res_im;
      out_sat <= res_sat;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.result_re = out_re;
  assign dout.result_im = out_im;
  assign dout.saturated = out_sat;

endmodule

>>> hdl/frc_cell.sv
`timescale 1ns / 1ps
// One tap cell: holds a coefficient and one slot of each delay line, and adds
// its product to the partial sums passing down the chain. Depends on frc_pkg.
module frc_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int ACC_BITS    = 40,
  parameter int IDX_W       = 8,
  parameter int TAP         = 0
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  frc_pkg::cell_ctl_t                      ctl,
  input  logic [frc_pkg::TAP_INDEX_BITS-1:0]      coef_idx,
  input  logic signed [COEF_BITS-1:0]             coef_data,
  input  logic [frc_pkg::ACTIVE_TAPS_BITS-1:0]    active_taps,
  input  logic signed [SAMPLE_BITS-1:0]           real_in,
  input  logic signed [SAMPLE_BITS-1:0]           cre_in,
  input  logic signed [SAMPLE_BITS-1:0]           cim_in,
  output logic signed [SAMPLE_BITS-1:0]           real_out,
  output logic signed [SAMPLE_BITS-1:0]           cre_out,
  output logic signed [SAMPLE_BITS-1:0]           cim_out,
  input  logic                                    tok_in,
  input  logic signed [ACC_BITS-1:0]              sum_re_in,
  input  logic signed [ACC_BITS-1:0]              sum_im_in,
  output logic                                    tok_out,
  output logic signed [ACC_BITS-1:0]              sum_re_out,
  output logic signed [ACC_BITS-1:0]              sum_im_out
);
  import frc_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

  logic signed [COEF_BITS-1:0] coef;
  logic signed [PROD_BITS-1:0] prod_re;
  logic signed [PROD_BITS-1:0] prod_im;
  logic signed [ACC_BITS-1:0]  term_re;
  logic signed [ACC_BITS-1:0]  term_im;
  logic                        hit;
  logic                        tap_on;

  assign hit    = (IDX_W'(coef_idx) == IDX_W'(TAP));
  assign tap_on = (IDX_W'(TAP) < IDX_W'(active_taps));

  always_comb begin
    prod_re = coef * (ctl.cplx ? cre_out : real_out);
    prod_im = coef * cim_out;
    term_re = tap_on ? ACC_BITS'(prod_re) : ACC_BITS'(0);
    term_im = tap_on ? ACC_BITS'(prod_im) : ACC_BITS'(0);
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we && hit) begin
      coef <= coef_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      real_out <= '0;
      cre_out  <= '0;
      cim_out  <= '0;
    end else begin
      if (ctl.shift_real) begin
        real_out <= real_in;
      end
      if (ctl.shift_cplx) begin
        cre_out <= cre_in;
        cim_out <= cim_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else if (ctl.adv) begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sum_re_out <= sum_re_in + term_re;
      sum_im_out <= sum_im_in + term_im;
    end
  end

endmodule

>>> hdl/frc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the FIR filter, bound to the top level.
// Depends on frc_pkg for the operation codes.
module frc_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [frc_pkg::OP_BITS-1:0]       operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [SAMPLE_BITS-1:0]     result_re,
  input logic signed [SAMPLE_BITS-1:0]     result_im,
  input logic                              saturated
);
  import frc_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = ~SMAX;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_re) &&
      $stable(result_im) && $stable(saturated))
    else $error("result word changed while stalled");

  // After a coefficient write or clear the input is ready again in the next cycle.
  a_cmd_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_WRITE || operation == OP_CLEAR) |=> in_ready)
    else $error("input stalled after a command word");

  // A sample word occupies the tap chain.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_REAL || operation == OP_COMPLEX) |=> !in_ready)
    else $error("input ready while a sample is in the chain");

  // Results only come out of a sweep, during which input is held off.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sweep");

  // A clipped result carries a range limit in at least one part.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> result_re == SMAX || result_re == SMIN ||
      result_im == SMAX || result_im == SMIN)
    else $error("saturated flag without a clipped part");

endmodule

bind fir_filter_real_complex frc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_frc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .operation (din.operation),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .result_re (dout.result_re),
  .result_im (dout.result_im),
  .saturated (dout.saturated)
);
